// ===== sv/chmap_pkg.sv =====
// shared types, constants and hash helpers for the chained hash map
package chmap_pkg;

  localparam int unsigned BucketsDefault = 1021;
  localparam int unsigned NodesDefault   = 1024;

  localparam logic [63:0] MixMulA = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MixMulB = 64'h94d049bb133111eb;

  typedef enum logic [1:0] {
    OP_PUT    = 2'd0,
    OP_GET    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_DUP     = 2'd1,
    ST_MISSING = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]  op;
    logic [63:0] key;
    logic [63:0] value;
    logic        overwrite;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] found_value;
    logic [10:0] entry_total;
    logic [31:0] collisions;
  } rsp_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_MOD,
    S_HEAD_RD,
    S_HEAD_WAIT,
    S_NODE_RD,
    S_NODE_CHK,
    S_FREE_RD,
    S_FREE_WAIT,
    S_COMMIT
  } state_e;

endpackage

// ===== sv/chmap_hash.sv =====
// splitmix64 finalizer and bucket reduction, multicycle with 32x32 partial products
module chmap_hash #(
  parameter int unsigned Buckets = chmap_pkg::BucketsDefault,
  parameter int unsigned BW      = $clog2(Buckets)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [63:0]   key_i,
  output logic          done_o,
  output logic [BW-1:0] bucket_o
);

  // sequence: load, three partial products and a finish step per multiply,
  // then four 16-bit digits of the modulo, each a multiply and a correction step
  localparam logic [31:0] BucketsW = 32'(Buckets);
  // scaled reciprocal of the bucket count, off by at most one in the quotient
  localparam logic [31:0] RecipM = 32'((64'd1 << (31 + BW)) / 64'(Buckets));

  logic [3:0]    ph_q, ph_d;
  logic [63:0]   x_q, x_d;
  logic [63:0]   acc_q, acc_d;
  logic [63:0]   mul_q, mul_d;
  logic [31:0]   v_q, v_d;
  logic [1:0]    dig_q, dig_d;
  logic [BW-1:0] rem_q, rem_d;
  logic          busy_q, busy_d;
  logic          done_q, done_d;

  logic [31:0] pa, pb;
  logic [63:0] pp;
  logic [31:0] qt, qmul, rr, rfix;

  // pick partial-product operands by phase
  always_comb begin
    pa = 32'd0;
    pb = 32'd0;
    case (ph_q)
      4'd1: begin pa = x_q[31:0];  pb = mul_q[31:0];  end
      4'd2: begin pa = x_q[31:0];  pb = mul_q[63:32]; end
      4'd3: begin pa = x_q[63:32]; pb = mul_q[31:0];  end
      4'd5: begin pa = {16'(rem_q), x_q[63:48]}; pb = RecipM; end
      default: begin pa = 32'd0; pb = 32'd0; end
    endcase
  end
  assign pp = pa * pb;

  // digit remainder from the estimated quotient, with one correction
  assign qt   = 32'(acc_q >> (31 + BW));
  assign qmul = qt * BucketsW;
  assign rr   = v_q - qmul;
  assign rfix = (rr >= BucketsW) ? rr - BucketsW : rr;

  always_comb begin
    ph_d   = ph_q;
    x_d    = x_q;
    acc_d  = acc_q;
    mul_d  = mul_q;
    v_d    = v_q;
    dig_d  = dig_q;
    rem_d  = rem_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i && !busy_q) begin
      busy_d = 1'b1;
      x_d    = key_i ^ (key_i >> 30);
      mul_d  = chmap_pkg::MixMulA;
      ph_d   = 4'd1;
      acc_d  = 64'd0;
    end else if (busy_q) begin
      case (ph_q)
        4'd1: begin acc_d = pp; ph_d = 4'd2; end
        4'd2: begin acc_d = acc_q + {pp[31:0], 32'd0}; ph_d = 4'd3; end
        4'd3: begin acc_d = acc_q + {pp[31:0], 32'd0}; ph_d = 4'd4; end
        4'd4: begin
          // finish one multiply and apply the following xor-shift
          if (mul_q == chmap_pkg::MixMulA) begin
            x_d   = acc_q ^ (acc_q >> 27);
            mul_d = chmap_pkg::MixMulB;
            ph_d  = 4'd1;
          end else begin
            x_d   = acc_q ^ (acc_q >> 31);
            ph_d  = 4'd5;
            dig_d = 2'd0;
            rem_d = '0;
          end
        end
        4'd5: begin
          // multiply the next partial dividend by the reciprocal
          acc_d = pp;
          v_d   = pa;
          x_d   = {x_q[47:0], 16'd0};
          ph_d  = 4'd6;
        end
        4'd6: begin
          rem_d = rfix[BW-1:0];
          dig_d = dig_q + 2'd1;
          if (dig_q == 2'd3) begin
            busy_d = 1'b0;
            done_d = 1'b1;
            ph_d   = 4'd0;
          end else begin
            ph_d = 4'd5;
          end
        end
        default: ph_d = 4'd0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= 4'd0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
      dig_q  <= 2'd0;
    end else begin
      ph_q   <= ph_d;
      busy_q <= busy_d;
      done_q <= done_d;
      dig_q  <= dig_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    acc_q <= acc_d;
    mul_q <= mul_d;
    v_q   <= v_d;
    rem_q <= rem_d;
  end

  assign done_o   = done_q;
  assign bucket_o = rem_q;

endmodule

// ===== sv/chained_hash_map_u64_unit.sv =====
// Chained hash map with 64-bit keys and values over a fixed node pool.
// After reset the unit sweeps the bucket-head memory, one entry a cycle
// (all Buckets entries, 1021 by default) before taking its first request. A
// request to an empty bucket then runs through these steps after it is
// accepted: start the hash, the hash unit itself (six 32x32 partial products
// for the two multiplies and a modulo by the bucket count in four 16-bit
// digits), a read of the bucket head, a read of the free-list link and a
// write-back. Each chain node visited adds a check, and each node after the
// first also a read. The result sits in an output register; the next request
// may be taken meanwhile, but it holds before write-back until that result
// has been transferred.
module chained_hash_map_u64_unit #(
  parameter int unsigned Buckets = chmap_pkg::BucketsDefault,
  parameter int unsigned Nodes   = chmap_pkg::NodesDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  chmap_pkg::req_t   in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output chmap_pkg::rsp_t   out_data_o
);

  localparam int unsigned BW = $clog2(Buckets);
  localparam int unsigned NW = $clog2(Nodes);
  localparam int unsigned PW = NW + 1;
  localparam logic [PW-1:0] Nil = PW'(Nodes);

  // memories
  logic [PW-1:0] head_mem [Buckets];
  logic [63:0]   key_mem  [Nodes];
  logic [63:0]   val_mem  [Nodes];
  logic [PW-1:0] link_mem [Nodes];

  chmap_pkg::state_e st_q, st_d;
  chmap_pkg::req_t   req_q;
  logic [BW-1:0]  bkt;
  logic           hdone;
  logic           hstart;

  logic [BW-1:0]  clr_q;
  logic [BW-1:0]  b_q;
  logic [PW-1:0]  head_q, cur_q, prev_q, hit_q, hitlink_q, newn_q;
  logic [PW-1:0]  steps_q;
  logic [PW-1:0]  fresh_q, freeh_q;
  logic [PW-1:0]  cnt_q;
  logic [31:0]    coll_q;
  logic [63:0]    found_q;
  logic [63:0]    rsp_found_q;
  logic [1:0]     status_q;
  logic           outv_q;

  // registered memory reads
  logic [PW-1:0]  head_rd_q;
  logic [63:0]    key_rd_q, val_rd_q;
  logic [PW-1:0]  link_rd_q;
  logic [NW-1:0]  nrd_addr;

  chmap_hash #(.Buckets(Buckets), .BW(BW)) u_hash (
    .clk_i, .rst_ni, .start_i(hstart), .key_i(req_q.key),
    .done_o(hdone), .bucket_o(bkt)
  );

  assign in_ready_o = (st_q == chmap_pkg::S_IDLE);
  assign hstart     = (st_q == chmap_pkg::S_HASH);

  // next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      chmap_pkg::S_CLEAR: if (clr_q == BW'(Buckets - 1)) st_d = chmap_pkg::S_IDLE;
      chmap_pkg::S_IDLE:  if (in_valid_i) st_d = chmap_pkg::S_HASH;
      chmap_pkg::S_HASH:  st_d = chmap_pkg::S_MOD;
      chmap_pkg::S_MOD:   if (hdone) st_d = chmap_pkg::S_HEAD_RD;
      chmap_pkg::S_HEAD_RD: st_d = chmap_pkg::S_HEAD_WAIT;
      chmap_pkg::S_HEAD_WAIT: begin
        if (head_rd_q < Nil) st_d = chmap_pkg::S_NODE_CHK;
        else                 st_d = chmap_pkg::S_FREE_RD;
      end
      chmap_pkg::S_NODE_RD: st_d = chmap_pkg::S_NODE_CHK;
      chmap_pkg::S_NODE_CHK: begin
        if (key_rd_q == req_q.key) st_d = chmap_pkg::S_FREE_RD;
        else if (link_rd_q < Nil && steps_q < Nil - PW'(1)) st_d = chmap_pkg::S_NODE_RD;
        else st_d = chmap_pkg::S_FREE_RD;
      end
      chmap_pkg::S_FREE_RD: st_d = chmap_pkg::S_FREE_WAIT;
      // hold until the previous result has been transferred
      chmap_pkg::S_FREE_WAIT: if (!outv_q || out_ready_i) st_d = chmap_pkg::S_COMMIT;
      chmap_pkg::S_COMMIT:    st_d = chmap_pkg::S_IDLE;
      default: st_d = chmap_pkg::S_IDLE;
    endcase
  end

  // node read address: head, next link, or free-list head
  always_comb begin
    nrd_addr = cur_q[NW-1:0];
    case (st_q)
      chmap_pkg::S_HEAD_WAIT: nrd_addr = head_rd_q[NW-1:0];
      chmap_pkg::S_NODE_CHK:  nrd_addr = link_rd_q[NW-1:0];
      chmap_pkg::S_FREE_RD:   nrd_addr = freeh_q[NW-1:0];
      chmap_pkg::S_FREE_WAIT: nrd_addr = freeh_q[NW-1:0];
      default:                nrd_addr = cur_q[NW-1:0];
    endcase
  end

  always_ff @(posedge clk_i) begin
    head_rd_q <= head_mem[b_q];
    key_rd_q  <= key_mem[nrd_addr];
    val_rd_q  <= val_mem[nrd_addr];
    link_rd_q <= link_mem[nrd_addr];
  end

  logic hit_now, put_new, ok_alloc;
  logic [PW-1:0] alloc;
  assign hit_now = (key_rd_q == req_q.key);
  assign put_new = (req_q.op == chmap_pkg::OP_PUT) && (hit_q == Nil);
  assign ok_alloc = (freeh_q < Nil) || (fresh_q < Nil);
  assign alloc = (freeh_q < Nil) ? freeh_q : fresh_q;

  // memory writes: bucket-head clear after reset, updates at commit
  always_ff @(posedge clk_i) begin
    if (st_q == chmap_pkg::S_CLEAR) begin
      head_mem[clr_q] <= Nil;
    end else if (st_q == chmap_pkg::S_COMMIT) begin
      if (put_new && ok_alloc) begin
        key_mem[alloc[NW-1:0]]  <= req_q.key;
        val_mem[alloc[NW-1:0]]  <= req_q.value;
        link_mem[alloc[NW-1:0]] <= head_q;
        head_mem[b_q]           <= alloc;
      end else if (req_q.op == chmap_pkg::OP_PUT && hit_q != Nil) begin
        if (req_q.overwrite) val_mem[hit_q[NW-1:0]] <= req_q.value;
      end else if (req_q.op == chmap_pkg::OP_REMOVE && hit_q != Nil) begin
        if (prev_q != Nil) link_mem[prev_q[NW-1:0]] <= hitlink_q;
        else               head_mem[b_q] <= hitlink_q;
        link_mem[hit_q[NW-1:0]] <= freeh_q;
      end
    end
  end

  // control and bookkeeping registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= chmap_pkg::S_CLEAR;
      clr_q   <= '0;
      fresh_q <= '0;
      freeh_q <= Nil;
      cnt_q   <= '0;
      coll_q  <= 32'd0;
      outv_q  <= 1'b0;
    end else begin
      st_q <= st_d;
      // result register is loaded at commit and emptied by its transfer
      if (st_q == chmap_pkg::S_COMMIT) outv_q <= 1'b1;
      else if (out_ready_i)            outv_q <= 1'b0;
      case (st_q)
        chmap_pkg::S_CLEAR: clr_q <= clr_q + BW'(1);
        chmap_pkg::S_COMMIT: begin
          if (put_new && ok_alloc) begin
            if (freeh_q < Nil) freeh_q <= link_rd_q;
            else               fresh_q <= fresh_q + PW'(1);
            if (head_q != Nil && coll_q != 32'hFFFF_FFFF) coll_q <= coll_q + 32'd1;
            if (cnt_q < PW'(Nodes)) cnt_q <= cnt_q + PW'(1);
          end else if (req_q.op == chmap_pkg::OP_REMOVE && hit_q != Nil) begin
            freeh_q <= hit_q;
            if (cnt_q != '0) cnt_q <= cnt_q - PW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers for the walk
  always_ff @(posedge clk_i) begin
    case (st_q)
      chmap_pkg::S_IDLE: if (in_valid_i) req_q <= in_data_i;
      chmap_pkg::S_MOD: if (hdone) b_q <= bkt;
      chmap_pkg::S_HEAD_RD: begin
        hit_q   <= Nil;
        prev_q  <= Nil;
        steps_q <= '0;
        found_q <= 64'd0;
      end
      chmap_pkg::S_HEAD_WAIT: begin
        head_q <= head_rd_q;
        cur_q  <= head_rd_q;
      end
      chmap_pkg::S_NODE_CHK: begin
        if (hit_now) begin
          hit_q     <= cur_q;
          hitlink_q <= link_rd_q;
          found_q   <= val_rd_q;
        end else begin
          prev_q  <= cur_q;
          cur_q   <= link_rd_q;
          steps_q <= steps_q + PW'(1);
        end
      end
      chmap_pkg::S_COMMIT: begin
        if (req_q.op == chmap_pkg::OP_PUT) begin
          if (hit_q != Nil) status_q <= req_q.overwrite ? chmap_pkg::ST_OK
                                                        : chmap_pkg::ST_DUP;
          else status_q <= ok_alloc ? chmap_pkg::ST_OK : chmap_pkg::ST_FULL;
        end else if ((req_q.op == chmap_pkg::OP_GET || req_q.op == chmap_pkg::OP_REMOVE)
                     && hit_q != Nil) begin
          status_q <= chmap_pkg::ST_OK;
        end else begin
          status_q <= chmap_pkg::ST_MISSING;
        end
        rsp_found_q <= (req_q.op == chmap_pkg::OP_GET && hit_q != Nil) ? found_q : 64'd0;
      end
      default: ;
    endcase
  end

  assign out_valid_o            = outv_q;
  assign out_data_o.status      = status_q;
  assign out_data_o.found_value = rsp_found_q;
  assign out_data_o.entry_total = 11'(cnt_q);
  assign out_data_o.collisions  = coll_q;

endmodule
